// ----- rtl/etpa_pkg.sv -----
// Package: constant tables and widths for the projected angle unit.
`default_nettype none
package etpa_pkg;
	localparam int TabLen = 24;
	localparam int Deg64Turn = 23040;
	localparam logic [31:0] InvGain32 = 32'h9B74EDA8;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_YAW_OFFSET = 2'd1;
	localparam logic [1:0] REG_ANGLE_OFFSET = 2'd2;
	localparam logic [1:0] REG_INVERT_DIR = 2'd3;

	typedef logic [31:0] atan_tab_t [TabLen];
	localparam atan_tab_t AtanTurn32 = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// per-step angle, rounded half up to f fractional bits of a turn
	function automatic logic [31:0] step_angle(input int i, input int f);
		logic [32:0] t;
		t = {1'b0, AtanTurn32[i]} + (33'd1 << (31 - f));
		return 32'(t[32:0] >> (32 - f));
	endfunction

	function automatic logic [31:0] inv_gain(input int f);
		logic [32:0] t;
		t = {1'b0, InvGain32} + (33'd1 << (31 - f));
		return 32'(t >> (32 - f));
	endfunction
endpackage
`default_nettype wire

// ----- rtl/euler_to_projected_angle_unit.sv -----
// Top level: yaw/pitch to projected turn fraction, fully pipelined CORDIC.
// Registers in order: s1-s3, rotation chain, s4-s6, vectoring chain, s7, output.
// Throughput: one word per cycle; a global stall freezes every stage.
// The two CORDIC chains (rotation, then vectoring) take one step a stage.
// Reset clears configuration registers and all stage valid bits.
`default_nettype none
module euler_to_projected_angle_unit
	import etpa_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire signed [14:0] yaw_deg,
	input  wire signed [13:0] pitch_deg,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [15:0] proj_angle,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [1:0]  cfg_index,
	input  wire [16:0] cfg_data
);
	localparam int F = FRAC_BITS;
	localparam int N = (CORDIC_STEPS < TabLen) ? CORDIC_STEPS : TabLen;
	localparam int W = F + 4;
	localparam int ZW = F + 3;
	localparam logic [F-1:0] Quarter = F'(1) << (F - 2);
	localparam logic [F-1:0] Half = F'(1) << (F - 1);
	// reciprocal of 23040 = 2^9 * 45: value * 2^F / 23040 via mult by ceil(2^K/45)
	localparam int K = 40;
	localparam longint Recip = ((64'd1 << K) + 64'd44) / 64'd45;

	logic en_q, inv_q;
	logic signed [14:0] yoff_q;
	logic [16:0] aoff_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0; inv_q <= 1'b0; yoff_q <= '0; aoff_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ENABLE: en_q <= cfg_data[0];
				REG_YAW_OFFSET: yoff_q <= cfg_data[14:0];
				REG_ANGLE_OFFSET: aoff_q <= cfg_data;
				REG_INVERT_DIR: inv_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stall: output register holds while downstream stalls
	logic adv;
	assign adv = ~(out_valid & out_stall);
	assign in_stall = ~adv;

	// s1: shifted degree values (numerator of phase)
	logic v_s1;
	logic [17:0] uy_s1, up_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid & en_q;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			uy_s1 <= 18'($signed(yaw_deg) + $signed(yoff_q) + 32'sd46080);
			up_s1 <= 18'($signed(pitch_deg) + 32'sd46080);
		end
	end

	// s2: (u*2^F + 11520) / 23040 = ((u*2^(F-9) + 22.5)...) via reciprocal
	localparam int NW = 18 + F + 1;
	logic v_s2;
	logic [F-1:0] py_s2, pp_s2;
	function automatic logic [F-1:0] to_phase(input logic [17:0] u);
		logic [NW-1:0] num;
		logic [NW+K-1:0] q;
		num = (NW'(u) << F) + NW'(Deg64Turn / 2);
		q = (NW+K)'((NW+K)'(num >> 9) * (NW+K)'(Recip));
		return F'(q >> K);
	endfunction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			py_s2 <= to_phase(uy_s1);
			pp_s2 <= to_phase(up_s1);
		end
	end

	// s3: quadrant fold
	logic v_s3;
	logic signed [ZW-1:0] zy_s3, zp_s3;
	logic fy_s3, fp_s3;
	function automatic logic [ZW:0] fold(input logic [F-1:0] p);
		logic signed [ZW-1:0] z;
		logic fl;
		z = ZW'(signed'({1'b0, p}));
		if (p >= Half) z = z - ZW'(signed'({1'b0, Half, 1'b0}));
		fl = 1'b0;
		if (z > ZW'(signed'({1'b0, Quarter}))) begin
			z = z - ZW'(signed'({1'b0, Half})); fl = 1'b1;
		end else if (z < -ZW'(signed'({1'b0, Quarter}))) begin
			z = z + ZW'(signed'({1'b0, Half})); fl = 1'b1;
		end
		return {fl, z};
	endfunction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			{fy_s3, zy_s3} <= fold(py_s2);
			{fp_s3, zp_s3} <= fold(pp_s2);
		end
	end

	// rotation chains (yaw and pitch side by side)
	logic signed [W-1:0] xy [N+1], yy [N+1], xp [N+1], yp [N+1];
	logic signed [ZW-1:0] zy [N+1], zp [N+1];
	logic [1:0] fl [N+1];
	logic [N:0] vr, vr2;
	localparam logic signed [W-1:0] X0 = W'(signed'({1'b0, inv_gain(F)}));
	assign xy[0] = X0; assign yy[0] = '0; assign zy[0] = zy_s3;
	assign xp[0] = X0; assign yp[0] = '0; assign zp[0] = zp_s3;
	assign fl[0] = {fy_s3, fp_s3};
	assign vr[0] = v_s3;
	assign vr2[0] = v_s3;
	for (genvar i = 0; i < N; i++) begin : g_rot
		etpa_cordic_stage #(.W(W), .ZW(ZW), .SH(i), .FB(F), .VECTOR(1'b0), .SW(2)) u_y (
			.clk, .arst_n, .adv, .vld_in(vr[i]), .x_in(xy[i]), .y_in(yy[i]),
			.z_in(zy[i]), .side_in(fl[i]), .vld_out(vr[i+1]), .x_out(xy[i+1]),
			.y_out(yy[i+1]), .z_out(zy[i+1]), .side_out(fl[i+1]));
		etpa_cordic_stage #(.W(W), .ZW(ZW), .SH(i), .FB(F), .VECTOR(1'b0), .SW(1)) u_p (
			.clk, .arst_n, .adv, .vld_in(vr2[i]), .x_in(xp[i]), .y_in(yp[i]),
			.z_in(zp[i]), .side_in(1'b0), .vld_out(vr2[i+1]), .x_out(xp[i+1]),
			.y_out(yp[i+1]), .z_out(zp[i+1]), .side_out());
	end

	// s4: signs applied; s5 registers the product cp*cy
	logic v_s4;
	logic signed [W-1:0] cy_s4, cp_s4, sp_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= vr[N];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			cy_s4 <= fl[N][1] ? -xy[N] : xy[N];
			cp_s4 <= fl[N][0] ? -xp[N] : xp[N];
			sp_s4 <= fl[N][0] ? -yp[N] : yp[N];
		end
	end
	logic v_s5;
	logic signed [W-1:0] lz_s5, ly_s5;
	logic signed [2*W-1:0] prod;
	assign prod = cp_s4 * cy_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			lz_s5 <= W'(prod >>> F);
			ly_s5 <= sp_s4;
		end
	end

	// s6: vectoring setup; side bits: {zero, pos, ly sign code}
	logic v_s6;
	logic signed [W-1:0] vx_s6, vy_s6;
	logic [3:0] sd_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			vx_s6 <= lz_s5[W-1] ? -lz_s5 : lz_s5;
			vy_s6 <= lz_s5[W-1] ? -ly_s5 : ly_s5;
			sd_s6 <= {lz_s5 == '0, ~lz_s5[W-1], ly_s5 > 0, ly_s5 < 0};
		end
	end

	logic signed [W-1:0] vx [N+1], vy [N+1];
	logic signed [ZW-1:0] vz [N+1];
	logic [3:0] sd [N+1];
	logic [N:0] vv;
	assign vx[0] = vx_s6; assign vy[0] = vy_s6; assign vz[0] = '0;
	assign sd[0] = sd_s6; assign vv[0] = v_s6;
	for (genvar i = 0; i < N; i++) begin : g_vec
		etpa_cordic_stage #(.W(W), .ZW(ZW), .SH(i), .FB(F), .VECTOR(1'b1), .SW(4)) u_v (
			.clk, .arst_n, .adv, .vld_in(vv[i]), .x_in(vx[i]), .y_in(vy[i]),
			.z_in(vz[i]), .side_in(sd[i]), .vld_out(vv[i+1]), .x_out(vx[i+1]),
			.y_out(vy[i+1]), .z_out(vz[i+1]), .side_out(sd[i+1]));
	end

	// s7: base angle plus offset
	logic v_s7;
	logic [F-1:0] r_s7;
	logic [F-1:0] rb, off;
	always_comb begin
		if (sd[N][3]) rb = sd[N][1] ? Half : (sd[N][0] ? '0 : Quarter);
		else rb = F'(vz[N]) + (sd[N][2] ? F'(3 * (2 ** (F - 2))) : Quarter);
		if (F >= 16) off = F'({15'd0, aoff_q} << (F >= 16 ? F - 16 : 0));
		else off = F'(aoff_q >> (F < 16 ? 16 - F : 0));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (adv) v_s7 <= vv[N];
	end
	always_ff @(posedge clk) begin
		if (adv) r_s7 <= rb + off;
	end

	// output register: invert and round to 16 bits
	localparam int RW = (F >= 16) ? F + 1 : 17;
	localparam int RSh = (F >= 16) ? F - 16 : 0;
	localparam int LSh = (F < 16) ? 16 - F : 0;
	localparam logic [RW-1:0] RndHalf = (F >= 17) ? RW'(1) << (F >= 17 ? F - 17 : 0) : '0;
	logic [F-1:0] ri;
	logic [RW-1:0] rr;
	always_comb begin
		ri = inv_q ? F'(-r_s7) : r_s7;
		if (F >= 16) rr = (RW'(ri) + RndHalf) >> RSh;
		else rr = RW'(ri) << LSh;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= v_s7;
	end
	always_ff @(posedge clk) begin
		if (adv) proj_angle <= rr[15:0];
	end
endmodule
`default_nettype wire

// ----- rtl/etpa_cordic_stage.sv -----
// One registered CORDIC micro-rotation with stall-aware valid bit.
`default_nettype none
module etpa_cordic_stage
	import etpa_pkg::*;
#(
	parameter int W = 20,
	parameter int ZW = 20,
	parameter int SH = 0,
	parameter int FB = 16,
	parameter bit VECTOR = 1'b0,
	parameter int SW = 1
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            adv,
	input  wire            vld_in,
	input  wire signed [W-1:0]  x_in,
	input  wire signed [W-1:0]  y_in,
	input  wire signed [ZW-1:0] z_in,
	input  wire [SW-1:0]   side_in,
	output logic           vld_out,
	output logic signed [W-1:0]  x_out,
	output logic signed [W-1:0]  y_out,
	output logic signed [ZW-1:0] z_out,
	output logic [SW-1:0]  side_out
);
	localparam logic [31:0] Ang = step_angle(SH, FB);
	logic signed [ZW-1:0] ang;
	logic dir;
	logic signed [W-1:0] xs, ys;
	assign ang = ZW'(signed'({1'b0, Ang}));
	assign xs = x_in >>> SH;
	assign ys = y_in >>> SH;
	assign dir = VECTOR ? ~y_in[W-1] : ~z_in[ZW-1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_out <= 1'b0;
		else if (adv) vld_out <= vld_in;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			side_out <= side_in;
			if (dir) begin
				x_out <= VECTOR ? x_in + ys : x_in - ys;
				y_out <= VECTOR ? y_in - xs : y_in + xs;
				z_out <= VECTOR ? z_in + ang : z_in - ang;
			end else begin
				x_out <= VECTOR ? x_in - ys : x_in + ys;
				y_out <= VECTOR ? y_in + xs : y_in - xs;
				z_out <= VECTOR ? z_in - ang : z_in + ang;
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/etpa_checker.sv -----
// Port-level checker for the projected angle unit, bound to the top level.
`default_nettype none
module etpa_checker (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_stall,
	input wire out_valid,
	input wire out_stall,
	input wire [15:0] proj_angle,
	input wire cfg_ready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(proj_angle))
		else $error("result word changed under stall");
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output free");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");
endmodule

bind euler_to_projected_angle_unit etpa_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .proj_angle, .cfg_ready);
`default_nettype wire
